@@ hw/rtl/sgc_pkg.sv @@
// sgc_pkg: shared types, codes and helper functions of the stepped gain controller
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package sgc_pkg;

    localparam int KEY_W   = 5;
    localparam int ADC_W   = 10;
    localparam int GAIN_W  = 4;
    localparam int TICK_W  = 4;
    localparam int EVENT_W = 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // highest gain step, the lowest is one
    localparam logic [GAIN_W-1:0] GAIN_STEPS = 4'd15;
    localparam logic [GAIN_W-1:0] GAIN_MIN   = 4'd1;
    localparam logic [TICK_W-1:0] TICK_MAX   = 4'd15;

    // keypad codes
    localparam logic [KEY_W-1:0] KEY_NONE = 5'd0;
    localparam logic [KEY_W-1:0] KEY_UP   = 5'd1;
    localparam logic [KEY_W-1:0] KEY_DOWN = 5'd2;
    localparam logic [KEY_W-1:0] KEY_AUTO = 5'd3;

    // configuration reset values
    localparam logic [ADC_W-1:0]  HIGH_CODE_RST   = 10'd614;
    localparam logic [ADC_W-1:0]  LOW_CODE_RST    = 10'd164;
    localparam logic [TICK_W-1:0] START_TICKS_RST = 4'd2;
    localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 4'd9;

    typedef enum logic [1:0] {
        REG_HIGH_CODE   = 2'd0,
        REG_LOW_CODE    = 2'd1,
        REG_START_TICKS = 2'd2,
        REG_LONG_TICKS  = 2'd3
    } reg_addr_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } ir_event_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_STARTED = 3'b010,
        PH_LONG    = 3'b100
    } pulse_phase_t;

    // step up with wrap to the lowest level
    function automatic logic [GAIN_W-1:0] gain_up(input logic [GAIN_W-1:0] g);
        gain_up = (g >= GAIN_STEPS) ? GAIN_MIN : g + GAIN_MIN;
    endfunction

    // step down with wrap to the highest level
    function automatic logic [GAIN_W-1:0] gain_down(input logic [GAIN_W-1:0] g);
        gain_down = (g <= GAIN_MIN) ? GAIN_STEPS : g - GAIN_MIN;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sgc_in_if.sv @@
// sgc_in_if: per-tick input channel (keypad code, infrared level, adc code)
// depends on sgc_pkg for field widths
`default_nettype none

interface sgc_in_if
    import sgc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  keypad_code;
    logic              ir_level;
    logic [ADC_W-1:0]  adc_sample;

    modport source (output valid, output keypad_code, output ir_level, output adc_sample,
                    input ready);
    modport sink   (input valid, input keypad_code, input ir_level, input adc_sample,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sgc_out_if.sv @@
// sgc_out_if: per-tick result channel (gain level, control lines, mode, pulse event)
// depends on sgc_pkg for field widths
`default_nettype none

interface sgc_out_if
    import sgc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [GAIN_W-1:0]  gain_level;
    logic [GAIN_W-1:0]  control_lines;
    logic               auto_enabled;
    logic [EVENT_W-1:0] ir_event;

    modport source (output valid, output gain_level, output control_lines,
                    output auto_enabled, output ir_event, input ready);
    modport sink   (input valid, input gain_level, input control_lines,
                    input auto_enabled, input ir_event, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/stepped_gain_controller.sv @@
// stepped_gain_controller: top level, gain state, pulse classifier and apb registers
// depends on sgc_pkg, sgc_in_if and sgc_out_if
`default_nettype none

// usage
//   item_in carries one transaction per 20 ms tick: keypad code, infrared line
//   level and a 10-bit adc code. result_out returns exactly one transaction
//   per input transaction: gain level, control lines (same binary value),
//   auto mode flag and the infrared pulse event found on that tick.
//   the apb port holds four registers at byte addresses 0, 4, 8, 12:
//   high_code, low_code, pulse_start_ticks, pulse_long_ticks; write them
//   only while no transaction is in flight.
// timing
//   an accepted transaction lands in the input register and is processed
//   in one pass when the result register is free and then held there for
//   result_out. one transaction per cycle is sustained unless result_out
//   is held off; the rate is set by the one-pass state update.
// stall
//   when result_out is held off, the result register keeps its value and
//   one more transaction may wait in the input register; ready drops only
//   when both are full.
// reset
//   rst_n clears both stages, sets gain to one, auto mode off, pulse
//   classifier idle and loads the register reset values.

module stepped_gain_controller
    import sgc_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    sgc_in_if.sink              item_in,
    sgc_out_if.source           result_out,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [ADDR_W-1:0]   paddr,
    input  wire  [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // configuration registers
    logic [ADC_W-1:0]  high_code_reg;
    logic [ADC_W-1:0]  low_code_reg;
    logic [TICK_W-1:0] start_ticks_reg;
    logic [TICK_W-1:0] long_ticks_reg;

    // input stage
    logic              s1_valid_reg;
    logic [KEY_W-1:0]  s1_key_reg;
    logic              s1_ir_reg;
    logic [ADC_W-1:0]  s1_adc_reg;

    // block state
    logic              key_held_reg,  key_held_next;
    pulse_phase_t      phase_reg,     phase_next;
    logic [TICK_W-1:0] ticks_reg,     ticks_next;
    logic [GAIN_W-1:0] gain_reg,      gain_next;
    logic              auto_reg,      auto_next;
    ir_event_t         event_next;

    logic              advance;
    logic              s1_fire;
    logic              pressed;
    logic [TICK_W-1:0] ticks_inc;
    logic [GAIN_W-1:0] gain_auto_dn;
    logic [GAIN_W-1:0] gain_auto;
    logic [GAIN_W-1:0] gain_key;
    logic              cfg_write;
    reg_addr_t         cfg_addr;

    // ------------------------------------------------------------------
    // apb register port, zero wait states
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_addr  = reg_addr_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_code_reg   <= HIGH_CODE_RST;
            low_code_reg    <= LOW_CODE_RST;
            start_ticks_reg <= START_TICKS_RST;
            long_ticks_reg  <= LONG_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                REG_HIGH_CODE:   high_code_reg   <= pwdata[ADC_W-1:0];
                REG_LOW_CODE:    low_code_reg    <= pwdata[ADC_W-1:0];
                REG_START_TICKS: start_ticks_reg <= pwdata[TICK_W-1:0];
                REG_LONG_TICKS:  long_ticks_reg  <= pwdata[TICK_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_addr)
            REG_HIGH_CODE:   prdata[ADC_W-1:0]  = high_code_reg;
            REG_LOW_CODE:    prdata[ADC_W-1:0]  = low_code_reg;
            REG_START_TICKS: prdata[TICK_W-1:0] = start_ticks_reg;
            REG_LONG_TICKS:  prdata[TICK_W-1:0] = long_ticks_reg;
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake: result register frees when empty or taken this cycle
    // ------------------------------------------------------------------
    assign advance       = !result_out.valid || result_out.ready;
    assign s1_fire       = s1_valid_reg && advance;
    assign item_in.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            s1_valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            s1_key_reg <= item_in.keypad_code;
            s1_ir_reg  <= item_in.ir_level;
            s1_adc_reg <= item_in.adc_sample;
        end
    end

    // ------------------------------------------------------------------
    // single pass update for the transaction held in the input register
    // ------------------------------------------------------------------

    // a key acts once, on the tick it turns nonzero after a release
    assign pressed       = !key_held_reg && (s1_key_reg != KEY_NONE);
    assign key_held_next = (s1_key_reg != KEY_NONE);

    // saturating high-tick count
    assign ticks_inc = (ticks_reg == TICK_MAX) ? TICK_MAX : ticks_reg + 4'd1;

    // infrared pulse classifier
    always_comb
    begin
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        event_next = EV_NONE;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (s1_ir_reg)
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= start_ticks_reg)
                    begin
                        phase_next = PH_STARTED;
                    end
                end
                else
                begin
                    ticks_next = '0;
                end
            end
            PH_STARTED:
            begin
                if (s1_ir_reg)
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= long_ticks_reg)
                    begin
                        phase_next = PH_LONG;
                    end
                end
                else
                begin
                    event_next = EV_SHORT;
                    ticks_next = '0;
                    phase_next = PH_IDLE;
                end
            end
            PH_LONG:
            begin
                if (!s1_ir_reg)
                begin
                    event_next = EV_LONG;
                    ticks_next = '0;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                ticks_next = '0;
            end
        endcase
    end

    // automatic gain uses the mode from the start of the tick, no wrap;
    // the decrease test comes first, the increase test sees its result
    assign gain_auto_dn = (auto_reg && (s1_adc_reg > high_code_reg) && (gain_reg > GAIN_MIN))
                        ? gain_reg - 4'd1 : gain_reg;
    assign gain_auto    = (auto_reg && (s1_adc_reg < low_code_reg)
                           && (gain_auto_dn < GAIN_STEPS))
                        ? gain_auto_dn + 4'd1 : gain_auto_dn;

    // key action, then infrared action, both with wrap
    always_comb
    begin
        gain_key  = gain_auto;
        auto_next = auto_reg;
        if (pressed)
        begin
            case (s1_key_reg)
                KEY_UP:   gain_key  = gain_up(gain_auto);
                KEY_DOWN: gain_key  = gain_down(gain_auto);
                KEY_AUTO: auto_next = !auto_reg;
                default:  ;
            endcase
        end
        case (event_next)
            EV_SHORT: gain_next = gain_up(gain_key);
            EV_LONG:  gain_next = gain_down(gain_key);
            default:  gain_next = gain_key;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_held_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            ticks_reg    <= '0;
            gain_reg     <= GAIN_MIN;
            auto_reg     <= 1'b0;
        end
        else if (s1_fire)
        begin
            key_held_reg <= key_held_next;
            phase_reg    <= phase_next;
            ticks_reg    <= ticks_next;
            gain_reg     <= gain_next;
            auto_reg     <= auto_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_out.valid <= 1'b0;
        end
        else if (advance)
        begin
            result_out.valid <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            result_out.gain_level    <= gain_next;
            result_out.control_lines <= gain_next;
            result_out.auto_enabled  <= auto_next;
            result_out.ir_event      <= event_next;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    gain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (result_out.gain_level >= GAIN_MIN)
                          && (result_out.gain_level <= GAIN_STEPS))
        else $error("gain level out of range");

    gain_held_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(gain_reg) && $stable(auto_reg) && $stable(phase_reg))
        else $error("state changed without a transaction");

    long_event_from_long_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (event_next == EV_LONG)) |-> (phase_reg == PH_LONG) && !s1_ir_reg)
        else $error("long pulse event outside long phase");

    result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> result_out.valid && (result_out.gain_level == gain_reg)
                 && (result_out.auto_enabled == auto_reg))
        else $error("result register does not follow state");

endmodule

`default_nettype wire

@@ tb/sgc_result_checker.sv @@
// sgc_result_checker: watches the tick and result channels and the apb writes of the
// stepped gain controller, predicts each result transaction and compares it in order
// depends on sgc_pkg for widths, key codes, register indexes and enums
`timescale 1ns / 1ps

module sgc_result_checker
    import sgc_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    // tick channel
    input  wire                 tick_valid,
    input  wire                 tick_ready,
    input  wire  [KEY_W-1:0]    keypad_code,
    input  wire                 ir_level,
    input  wire  [ADC_W-1:0]    adc_sample,
    // result channel
    input  wire                 result_valid,
    input  wire                 result_ready,
    input  wire  [GAIN_W-1:0]   gain_level,
    input  wire  [GAIN_W-1:0]   control_lines,
    input  wire                 auto_enabled,
    input  wire  [EVENT_W-1:0]  ir_event,
    // register port
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire                 pready,
    input  wire  [ADDR_W-1:0]   paddr,
    input  wire  [DATA_W-1:0]   pwdata,
    // to the test top
    output logic [31:0]         fail_count,
    output logic [31:0]         results_owed
);

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [GAIN_W-1:0] lines;
        logic              auto_on;
        ir_event_t         pulse_kind;
    } gain_result_t;

    // register copies
    logic [ADC_W-1:0]  high_code;
    logic [ADC_W-1:0]  low_code;
    logic [TICK_W-1:0] start_ticks;
    logic [TICK_W-1:0] long_ticks;

    // controller state
    logic              key_latched;
    pulse_phase_t      phase;
    logic [TICK_W-1:0] ticks;
    logic [GAIN_W-1:0] gain;
    logic              auto_on;

    gain_result_t      owed_results[$];
    int unsigned       mismatches;

    initial begin
        fail_count   = 0;
        results_owed = 0;
        mismatches   = 0;
    end

    function automatic logic [GAIN_W-1:0] wrap_step(input logic [GAIN_W-1:0] g,
                                                    input logic raise);
        if (raise)
            wrap_step = (g >= GAIN_STEPS) ? GAIN_MIN : g + 4'd1;
        else
            wrap_step = (g <= GAIN_MIN) ? GAIN_STEPS : g - 4'd1;
    endfunction

    task automatic advance_tick(input logic [KEY_W-1:0] k, input logic ir,
                                input logic [ADC_W-1:0] s, output gain_result_t r);
        logic      pressed;
        ir_event_t ev;
        pressed = 1'b0;
        ev      = EV_NONE;

        // a key acts once per press, until released
        if (!key_latched) begin
            if (k != KEY_NONE) begin
                key_latched = 1'b1;
                pressed     = 1'b1;
            end
        end
        else if (k == KEY_NONE) begin
            key_latched = 1'b0;
        end

        case (phase)
            PH_IDLE:
                if (ir) begin
                    if (ticks != TICK_MAX)
                        ticks++;
                    if (ticks >= start_ticks)
                        phase = PH_STARTED;
                end
                else begin
                    ticks = '0;
                end
            PH_STARTED:
                if (ir) begin
                    if (ticks != TICK_MAX)
                        ticks++;
                    if (ticks >= long_ticks)
                        phase = PH_LONG;
                end
                else begin
                    ev    = EV_SHORT;
                    ticks = '0;
                    phase = PH_IDLE;
                end
            default:
                if (!ir) begin
                    ev    = EV_LONG;
                    ticks = '0;
                    phase = PH_IDLE;
                end
        endcase

        // auto mode steps against the rails, decrease first
        if (auto_on) begin
            if (s > high_code && gain > GAIN_MIN)
                gain--;
            if (s < low_code && gain < GAIN_STEPS)
                gain++;
        end

        if (pressed) begin
            case (k)
                KEY_UP:   gain = wrap_step(gain, 1'b1);
                KEY_DOWN: gain = wrap_step(gain, 1'b0);
                KEY_AUTO: auto_on = ~auto_on;
                default:  ;
            endcase
        end

        if (ev == EV_SHORT)
            gain = wrap_step(gain, 1'b1);
        else if (ev == EV_LONG)
            gain = wrap_step(gain, 1'b0);

        r.gain       = gain;
        r.lines      = gain;
        r.auto_on    = auto_on;
        r.pulse_kind = ev;
    endtask

    always @(posedge clk) begin : watch
        gain_result_t want;
        gain_result_t got;
        if (!rst_n) begin
            high_code   = HIGH_CODE_RST;
            low_code    = LOW_CODE_RST;
            start_ticks = START_TICKS_RST;
            long_ticks  = LONG_TICKS_RST;
            key_latched = 1'b0;
            phase       = PH_IDLE;
            ticks       = '0;
            gain        = GAIN_MIN;
            auto_on     = 1'b0;
            owed_results.delete();
        end
        else begin
            // results first: a tick taken on this edge cannot come out yet
            if (result_valid && result_ready) begin
                got.gain       = gain_level;
                got.lines      = control_lines;
                got.auto_on    = auto_enabled;
                got.pulse_kind = ir_event_t'(ir_event);
                if (owed_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t unexpected result: gain %0d lines %0d auto %0d event %0d",
                                 $realtime, got.gain, got.lines, got.auto_on, got.pulse_kind);
                    mismatches++;
                end
                else begin
                    want = owed_results.pop_front();
                    if (got.gain !== want.gain || got.lines !== want.lines ||
                        got.auto_on !== want.auto_on || got.pulse_kind !== want.pulse_kind)
                    begin
                        if (mismatches < 10)
                            $display("%0t result mismatch: expected gain %0d lines %0d auto %0d %s",
                                     $realtime, want.gain, want.lines, want.auto_on,
                                     $sformatf("event %0d, got gain %0d lines %0d auto %0d event %0d",
                                               want.pulse_kind, got.gain, got.lines,
                                               got.auto_on, got.pulse_kind));
                        mismatches++;
                    end
                end
            end

            if (tick_valid && tick_ready) begin
                advance_tick(keypad_code, ir_level, adc_sample, want);
                owed_results.push_back(want);
            end

            if (psel && penable && pwrite && pready) begin
                case (reg_addr_t'(paddr[ADDR_W-1:2]))
                    REG_HIGH_CODE:   high_code   = pwdata[ADC_W-1:0];
                    REG_LOW_CODE:    low_code    = pwdata[ADC_W-1:0];
                    REG_START_TICKS: start_ticks = pwdata[TICK_W-1:0];
                    REG_LONG_TICKS:  long_ticks  = pwdata[TICK_W-1:0];
                    default:         ;
                endcase
            end
        end
        fail_count   <= mismatches;
        results_owed <= owed_results.size();
    end

endmodule

@@ tb/stepped_gain_controller_test.sv @@
// stepped_gain_controller_test: top of the gain controller bench, clock, reset,
// register writes, tick stimulus, receiver stalls and the final verdict
// depends on sgc_pkg, sgc_in_if, sgc_out_if, stepped_gain_controller, sgc_result_checker
`timescale 1ns / 1ps

module stepped_gain_controller_test;
    import sgc_pkg::*;

    // generous bound on the run length
    localparam int CYCLE_LIMIT     = 200000;
    // long receiver hold-off, fills both stages so the tick channel stalls
    localparam int HOLD_OFF_CYCLES = 60;
    // quiet cycles after the last result, two stages deep plus margin
    localparam int SETTLE_CYCLES   = 8;

    logic clk;
    logic rst_n;

    sgc_in_if  tick_in();
    sgc_out_if result_out();

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic [31:0] fail_count;
    logic [31:0] results_owed;

    int unsigned cycle_count = 0;

    // idling knobs, percent of cycles
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    bit          hold_off_req       = 1'b0;

    // shadow of the adc window, only used to aim samples near the thresholds
    int cfg_high = HIGH_CODE_RST;
    int cfg_low  = LOW_CODE_RST;

    // random tick generator state
    int unsigned      ir_high_left = 0;
    int unsigned      ir_low_left  = 0;
    int unsigned      key_left     = 0;
    logic [KEY_W-1:0] key_now      = KEY_NONE;

    stepped_gain_controller uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (tick_in),
        .result_out (result_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    sgc_result_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_valid    (tick_in.valid),
        .tick_ready    (tick_in.ready),
        .keypad_code   (tick_in.keypad_code),
        .ir_level      (tick_in.ir_level),
        .adc_sample    (tick_in.adc_sample),
        .result_valid  (result_out.valid),
        .result_ready  (result_out.ready),
        .gain_level    (result_out.gain_level),
        .control_lines (result_out.control_lines),
        .auto_enabled  (result_out.auto_enabled),
        .ir_event      (result_out.ir_event),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .results_owed  (results_owed)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // watchdog, a hung handshake ends the run here
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("stepped_gain_controller_test: errors");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when the stimulus asks for one
    initial begin
        int held;
        result_out.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                held = 0;
                while (held < HOLD_OFF_CYCLES) begin
                    result_out.ready <= 1'b0;
                    @(posedge clk);
                    held++;
                end
            end
            result_out.ready <= (receiver_stall_pct == 0) ||
                                ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // one register write, setup then access; psel stays up for back-to-back writes
    task automatic write_reg(input reg_addr_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    // only called with nothing in flight
    task automatic configure(input int high, input int low, input int start, input int long_at);
        write_reg(REG_HIGH_CODE,   DATA_W'(high));
        write_reg(REG_LOW_CODE,    DATA_W'(low));
        write_reg(REG_START_TICKS, DATA_W'(start));
        write_reg(REG_LONG_TICKS,  DATA_W'(long_at));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_high = high;
        cfg_low  = low;
    endtask

    // offer one tick transaction, with random sender gaps in front of it
    task automatic send_tick(input logic [KEY_W-1:0] k, input logic ir,
                             input logic [ADC_W-1:0] a);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            tick_in.valid <= 1'b0;
            @(posedge clk);
        end
        tick_in.valid       <= 1'b1;
        tick_in.keypad_code <= k;
        tick_in.ir_level    <= ir;
        tick_in.adc_sample  <= a;
        @(posedge clk);
        while (!tick_in.ready)
            @(posedge clk);
    endtask

    // stop offering and wait until every result has come back
    task automatic drain();
        tick_in.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sample a couple of codes either side of a threshold
    function automatic logic [ADC_W-1:0] adc_near(input int centre);
        int v;
        v = centre + int'($urandom_range(4)) - 2;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        adc_near = ADC_W'(v);
    endfunction

    // well-formed stimulus: infrared pulses of every length up to past saturation,
    // key presses held for a few ticks, samples aimed at the adc window edges
    task automatic compose_tick(output logic [KEY_W-1:0] k, output logic ir,
                                output logic [ADC_W-1:0] a);
        if (ir_high_left == 0 && ir_low_left == 0) begin
            if ($urandom_range(9) == 0) begin
                // noise, a lone tick of either level
                ir_high_left = $urandom_range(1);
                ir_low_left  = 1 - ir_high_left;
            end
            else begin
                ir_high_left = $urandom_range(1, 17);
                ir_low_left  = $urandom_range(1, 3);
            end
        end
        if (ir_high_left != 0) begin
            ir = 1'b1;
            ir_high_left--;
        end
        else begin
            ir = 1'b0;
            ir_low_left--;
        end

        if (key_left == 0) begin
            key_left = $urandom_range(1, 4);
            case ($urandom_range(9))
                0, 1, 2, 3: key_now = KEY_NONE;
                4:          key_now = KEY_UP;
                5:          key_now = KEY_DOWN;
                6:          key_now = KEY_AUTO;
                7:          key_now = KEY_W'($urandom_range(1, 3));
                8:          key_now = KEY_W'($urandom_range(4, 16));
                default:    key_now = KEY_W'($urandom_range(17, 31));
            endcase
        end
        key_left--;
        k = key_now;
        // a held key that bounces to another code is still the same press
        if (key_now != KEY_NONE && $urandom_range(7) == 0)
            k = KEY_W'($urandom_range(1, 31));

        case ($urandom_range(4))
            0:       a = ADC_W'($urandom_range(1023));
            1:       a = adc_near(cfg_high);
            2:       a = adc_near(cfg_low);
            3:       a = $urandom_range(1) ? 10'd1023 : 10'd0;
            default: a = ADC_W'($urandom_range(200, 600));
        endcase
    endtask

    task automatic run_phase(input int high, input int low, input int start, input int long_at,
                             input int unsigned idle_pct, input int unsigned stall_pct,
                             input int count, input bit hold_off);
        logic [KEY_W-1:0] k;
        logic             ir;
        logic [ADC_W-1:0] a;
        configure(high, low, start, long_at);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        if (hold_off)
            hold_off_req = 1'b1;
        repeat (count) begin
            compose_tick(k, ir, a);
            send_tick(k, ir, a);
        end
        drain();
    endtask

    initial begin
        int i;
        rst_n               <= 1'b0;
        tick_in.valid       <= 1'b0;
        tick_in.keypad_code <= KEY_NONE;
        tick_in.ir_level    <= 1'b0;
        tick_in.adc_sample  <= '0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset window and pulse thresholds, gain starts at one
        configure(HIGH_CODE_RST, LOW_CODE_RST, START_TICKS_RST, LONG_TICKS_RST);
        send_tick(KEY_NONE, 1'b0, 10'd0);      // quiet tick
        send_tick(KEY_DOWN, 1'b1, 10'd1023);   // down wraps to the top, pulse begins
        send_tick(KEY_NONE, 1'b1, 10'd512);    // pulse counts as started
        send_tick(KEY_UP,   1'b0, 10'd512);    // up wraps to one, short pulse in the same tick
        send_tick(KEY_UP,   1'b0, 10'd512);    // still held, no action
        send_tick(KEY_NONE, 1'b0, 10'd0);      // release, auto still off
        send_tick(KEY_AUTO, 1'b0, 10'd0);      // auto on, this tick still uses the old mode
        send_tick(KEY_NONE, 1'b0, 10'd0);      // below window, step up
        send_tick(KEY_NONE, 1'b0, 10'd1023);   // above window, step down
        send_tick(KEY_NONE, 1'b0, 10'd1023);
        send_tick(KEY_NONE, 1'b0, 10'd1023);   // at the bottom, no wrap in auto mode
        send_tick(5'd16,    1'b0, 10'd614);    // unused key, sample on the upper threshold
        send_tick(KEY_NONE, 1'b0, 10'd164);    // on the lower threshold
        send_tick(KEY_NONE, 1'b0, 10'd163);    // just below, step up
        send_tick(KEY_NONE, 1'b0, 10'd615);    // just above, step down
        // long pulse with key traffic on top, auto switched off part way
        for (i = 0; i < 10; i++)
            send_tick((i == 0) ? 5'd31 : ((i == 4) ? KEY_AUTO : KEY_NONE), 1'b1, 10'd0);
        send_tick(KEY_NONE, 1'b0, 10'd0);      // long pulse ends
        drain();

        // random part over several register settings and idling patterns
        // window that never fires, low pulse thresholds, no idling
        run_phase(1023, 0, 1, 2, 0, 0, 110, 1'b0);
        // crossed window, both steps can apply; largest thresholds; sender gaps
        run_phase(0, 1023, 15, 15, 50, 0, 110, 1'b0);
        // reset setting, receiver stalls plus one long hold-off
        run_phase(HIGH_CODE_RST, LOW_CODE_RST, START_TICKS_RST, LONG_TICKS_RST,
                  0, 50, 160, 1'b1);
        // random setting, both sides idle
        run_phase($urandom_range(1023), $urandom_range(1023), $urandom_range(15),
                  $urandom_range(15), 38, 38, 160, 1'b0);
        // long threshold below the start threshold, crossed window, no idling
        run_phase(300, 700, 6, 3, 0, 0, 80, 1'b0);
        // zero thresholds, the start one met on the first high tick
        run_phase(700, 200, 0, 0, 38, 38, 80, 1'b0);

        if (fail_count == 0 && results_owed == 0)
            $display("stepped_gain_controller_test: clean");
        else
            $display("stepped_gain_controller_test: errors");
        $finish;
    end

endmodule
